// ===== src/register_pool_allocator_assert.svh =====
// assertion macros for the register pool allocator
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef REGISTER_POOL_ALLOCATOR_ASSERT_SVH
`define REGISTER_POOL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define RPA_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("register_pool_allocator: assertion failed");
// next-cycle implication
`define RPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("register_pool_allocator: assertion failed");
`else
`define RPA_ASSERT(label, ante, cons)
`define RPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/rpa_pkg.sv =====
// constants and request codes for the register pool allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

  // pool geometry
  localparam int NUM_REGS   = 16;
  localparam int OWNER_BITS = 16;
  localparam int IDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_W      = $clog2(NUM_REGS + 1);

  // item field widths
  localparam int REQ_W       = 2;
  localparam int OWNER_IN_W  = 16;
  localparam int SEL_W       = 4;
  localparam int IDX_OUT_W   = 4;
  localparam int IN_DATA_W   = ((OWNER_IN_W + SEL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((IDX_OUT_W + 7) / 8) * 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PREALLOC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE  = 2'd2;

endpackage

`default_nettype wire

// ===== src/register_pool_allocator.sv =====
// register pool allocator: busy bitmap, owner table and a one-entry-per-cycle scanner
// depends on rpa_pkg and register_pool_allocator_assert.svh
//
// usage:
//   requests come in on the s_axis channel; req_type rides in tuser, owner_id and
//   reg_select in tdata. each request yields exactly one result item on m_axis:
//   reg_index in tdata, ok in tuser (reg_index reads zero when ok is low).
//   allocate picks the lowest free register, preallocate claims reg_select,
//   release frees the lowest busy register owned by owner_id.
//   the block takes one request at a time: s_axis_tready is high only while idle.
//   preallocate and unused codes skip the scan and go straight to the result
//   stage; allocate and release scan from index 0 up to the hit, or over the
//   whole pool when nothing matches. the scanner reads one owner table entry
//   per cycle through the single read port and compares it the cycle after.
//   a finished result sits in the output register; while the receiver stalls the
//   next request is still accepted and scanned, and its result waits until the
//   output register frees up.
//   reset marks every register free and empties the output register; owner
//   entries are left as they are and only read for busy registers.
`timescale 1ns / 1ps
`default_nettype none

`include "register_pool_allocator_assert.svh"

module register_pool_allocator
  import rpa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // owner_id[15:0], reg_select[19:16]
  input  wire logic [REQ_W-1:0]      s_axis_tuser,  // req_type[1:0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // reg_index[3:0]
  output logic                       m_axis_tuser   // ok[0]
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [OWNER_BITS-1:0] rd_owner_q;
  logic [NUM_REGS-1:0]   busy_q, busy_d;
  logic [REQ_W-1:0]      req_q, req_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  logic                  res_ok_q, res_ok_d;
  logic                  m_valid_q, m_valid_d;
  logic [IDX_OUT_W-1:0]  m_idx_q, m_idx_d;
  logic                  m_ok_q, m_ok_d;

  logic [OWNER_BITS-1:0] owner_mem [NUM_REGS];
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [OWNER_BITS-1:0] wr_data;

  logic                  in_acc;
  logic [REQ_W-1:0]      in_req;
  logic [OWNER_BITS-1:0] in_owner;
  logic [SEL_W-1:0]      in_sel;
  logic                  sel_in_pool;
  logic                  hit;
  logic                  last_idx;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_req        = s_axis_tuser;
  assign in_owner      = OWNER_BITS'(s_axis_tdata[OWNER_IN_W-1:0]);
  assign in_sel        = s_axis_tdata[OWNER_IN_W +: SEL_W];
  assign sel_in_pool   = (32'(in_sel) < NUM_REGS);

  // shared compare: free entry for allocate, busy entry with matching owner for release
  always_comb begin
    hit = 1'b0;
    if (rd_vld_q) begin
      if (req_q == REQ_ALLOC) begin
        hit = !busy_q[rd_idx_q];
      end else begin
        hit = busy_q[rd_idx_q] && (rd_owner_q == owner_q);
      end
    end
  end
  assign last_idx = (rd_idx_q == IDX_W'(NUM_REGS - 1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_vld_d  = 1'b0;
    busy_d    = busy_q;
    req_d     = req_q;
    owner_d   = owner_q;
    res_idx_d = res_idx_q;
    res_ok_d  = res_ok_q;
    m_valid_d = m_valid_q;
    m_idx_d   = m_idx_q;
    m_ok_d    = m_ok_q;
    wr_en     = 1'b0;
    wr_addr   = IDX_W'(in_sel);
    wr_data   = in_owner;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d     = in_req;
          owner_d   = in_owner;
          res_idx_d = '0;
          res_ok_d  = 1'b0;
          cnt_d     = '0;
          if (in_req == REQ_ALLOC || in_req == REQ_RELEASE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
            if (in_req == REQ_PREALLOC && sel_in_pool) begin
              wr_en     = 1'b1;
              busy_d[IDX_W'(in_sel)] = 1'b1;
              res_idx_d = IDX_W'(in_sel);
              res_ok_d  = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q < CNT_W'(NUM_REGS)) begin
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
        end
        if (hit) begin
          rd_vld_d  = 1'b0;
          state_d   = ST_DONE;
          res_idx_d = rd_idx_q;
          res_ok_d  = 1'b1;
          if (req_q == REQ_ALLOC) begin
            busy_d[rd_idx_q] = 1'b1;
            wr_en   = 1'b1;
            wr_addr = rd_idx_q;
            wr_data = owner_q;
          end else begin
            busy_d[rd_idx_q] = 1'b0;
          end
        end else if (rd_vld_q && last_idx) begin
          rd_vld_d = 1'b0;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_idx_d   = IDX_OUT_W'(res_idx_q);
          m_ok_d    = res_ok_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      busy_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      busy_q    <= busy_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    owner_q   <= owner_d;
    res_idx_q <= res_idx_d;
    res_ok_q  <= res_ok_d;
    m_idx_q   <= m_idx_d;
    m_ok_q    <= m_ok_d;
    rd_idx_q  <= cnt_q[IDX_W-1:0];
  end

  // owner table: one write port, one registered read port driven by the scan counter
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      owner_mem[wr_addr] <= wr_data;
    end
    rd_owner_q <= owner_mem[cnt_q[IDX_W-1:0]];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(m_idx_q);
  assign m_axis_tuser  = m_ok_q;

  `RPA_ASSERT(a_rd_only_in_scan, rd_vld_q, state_q == ST_SCAN)
  `RPA_ASSERT(a_cnt_in_range, 1'b1, cnt_q <= CNT_W'(NUM_REGS))
  `RPA_ASSERT(a_fail_zero_index, m_valid_q && !m_ok_q, m_idx_q == '0)
  `RPA_ASSERT_NEXT(a_alloc_sets_busy, state_q == ST_SCAN && hit && req_q == REQ_ALLOC,
                   busy_q[$past(rd_idx_q)])
  `RPA_ASSERT_NEXT(a_release_clears_busy, state_q == ST_SCAN && hit && req_q == REQ_RELEASE,
                   !busy_q[$past(rd_idx_q)])

endmodule

`default_nettype wire
